>>> sv/cgr_pkg.sv
`timescale 1ns / 1ps
package cgr_pkg;

  localparam int LANE_W   = 20;
  localparam int VEC_W    = 60;
  localparam int RES_W    = 13;
  localparam int PIX_W    = 16;
  localparam int OFS_W    = 18;
  localparam int PROD_W   = OFS_W + LANE_W;
  localparam int SUM_W    = 41;
  localparam int NORM_W   = 30;
  localparam int LEN_W    = 6;
  localparam int Q_W      = 62;
  localparam int ROOT_W   = 64;
  localparam int ROOT_STEPS = 32;
  localparam int FRAC_W   = 14;
  localparam int QUOT_W   = FRAC_W + 1;
  localparam int DIV_STEPS = QUOT_W;
  localparam int REM_W    = 47;
  localparam int DIR_W    = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_VIEW_DIR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_STEP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_STEP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IMG_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IMG_HEIGHT = 3'd5;

  localparam logic [VEC_W-1:0] VIEW_DIR_RST = 60'd68719476736;
  localparam logic [VEC_W-1:0] COL_STEP_RST = 60'd100910978174025728;
  localparam logic [VEC_W-1:0] ROW_STEP_RST = 60'd956798;

  typedef logic [NORM_W-1:0] norm_vec_t [3];

endpackage

>>> sv/camera_ray_generator_unit.sv
`timescale 1ns / 1ps
// Pinhole camera ray generator.
// The input stream carries one pixel sample per transaction: in_tdata holds pixel_x
// (unsigned Q12.4) in bits 15:0 and pixel_y in bits 31:16. For each sample the block
// emits one ray on the output stream: three signed Q2.14 unit direction components,
// the packed camera origin and, in out_tuser, a flag that marks a zero direction sum.
// The camera is set up through the write port (index, data, write enable); the user must
// change registers only while no ray is in flight. The block itself does not enforce this.
// The datapath is a pipeline of 56 register stages: eight for offsets, products, sums,
// range finding, scaling, squares and their sum, 32 for the square root (one result bit
// per stage) and 15 for the per-component division, followed by the output register.
// One ray leaves per cycle in steady state while out_tready does not hold the output.
// When the receiver holds out_tready low while a ray waits, the whole pipeline freezes
// and in_tready drops; nothing is lost or repeated. Bubbles do not stall it.
// Reset empties the pipeline and loads the default camera.
module camera_ray_generator_unit
  import cgr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // pixel_x [15:0], pixel_y [31:16]
  input  logic [31:0]          in_tdata,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // ray_dir_x [15:0], ray_dir_y [31:16], ray_dir_z [47:32], ray_origin [107:48], zero pad
  output logic [111:0]         out_tdata,
  // degenerate [0]
  output logic [0:0]           out_tuser,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [VEC_W-1:0]     cfg_wdata
);

  logic [VEC_W-1:0] view_dir_r, col_step_r, row_step_r, origin_r;
  logic [RES_W-1:0] img_w_r, img_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_dir_r <= VIEW_DIR_RST;
      col_step_r <= COL_STEP_RST;
      row_step_r <= ROW_STEP_RST;
      origin_r   <= '0;
      img_w_r    <= RES_W'(1);
      img_h_r    <= RES_W'(1);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_VIEW_DIR:   view_dir_r <= cfg_wdata;
        REG_COL_STEP:   col_step_r <= cfg_wdata;
        REG_ROW_STEP:   row_step_r <= cfg_wdata;
        REG_ORIGIN:     origin_r   <= cfg_wdata;
        REG_IMG_WIDTH:  img_w_r    <= cfg_wdata[RES_W-1:0];
        REG_IMG_HEIGHT: img_h_r    <= cfg_wdata[RES_W-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic out_valid_r;
  assign en = !out_valid_r || out_tready;
  assign in_tready = en;

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r;
  logic [ROOT_STEPS-1:0] sv_r;
  logic [DIV_STEPS-1:0]  dv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
      v5_r <= 1'b0; v6_r <= 1'b0; v7_r <= 1'b0; v8_r <= 1'b0;
      sv_r <= '0;
      dv_r <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r; v5_r <= v4_r;
      v6_r <= v5_r; v7_r <= v6_r; v8_r <= v7_r;
      sv_r <= {sv_r[ROOT_STEPS-2:0], v8_r};
      dv_r <= {dv_r[DIV_STEPS-2:0], sv_r[ROOT_STEPS-1]};
      out_valid_r <= dv_r[DIV_STEPS-1];
    end
  end

  // Stage 1: pixel offsets from the image center.
  logic signed [OFS_W-1:0] tx_r, ty_r;
  logic [RES_W-1:0] w_eff, h_eff;
  assign w_eff = (img_w_r == '0) ? RES_W'(1) : img_w_r;
  assign h_eff = (img_h_r == '0) ? RES_W'(1) : img_h_r;

  always_ff @(posedge clk) begin
    if (en) begin
      tx_r <= signed'({2'b00, in_tdata[PIX_W-1:0]} - {2'b00, w_eff, 3'b000});
      ty_r <= signed'({2'b00, in_tdata[2*PIX_W-1:PIX_W]} - {2'b00, h_eff, 3'b000});
    end
  end

  // Stage 2: products.
  logic signed [PROD_W-1:0] pc_r [3];
  logic signed [PROD_W-1:0] pr_r [3];
  logic signed [LANE_W+3:0] pd_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pc_r[i] <= signed'(col_step_r[LANE_W*i +: LANE_W]) * tx_r;
        pr_r[i] <= signed'(row_step_r[LANE_W*i +: LANE_W]) * ty_r;
        pd_r[i] <= signed'({view_dir_r[LANE_W*i +: LANE_W], 4'b0000});
      end
    end
  end

  // Stage 3: sums split into sign and magnitude.
  logic [SUM_W-1:0] mag3_r [3];
  logic [2:0]       neg3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        logic signed [SUM_W-1:0] s;
        s = SUM_W'(pd_r[i]) + SUM_W'(pc_r[i]) + SUM_W'(pr_r[i]);
        neg3_r[i] <= s[SUM_W-1];
        mag3_r[i] <= s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
      end
    end
  end

  // Stage 4: largest magnitude.
  logic [SUM_W-1:0] mag4_r [3];
  logic [2:0]       neg4_r;
  logic [SUM_W-1:0] mx4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      logic [SUM_W-1:0] m01;
      m01 = (mag3_r[0] > mag3_r[1]) ? mag3_r[0] : mag3_r[1];
      mx4_r  <= (m01 > mag3_r[2]) ? m01 : mag3_r[2];
      mag4_r <= mag3_r;
      neg4_r <= neg3_r;
    end
  end

  // Stage 5: bit length of the largest magnitude.
  logic [SUM_W-1:0] mag5_r [3];
  logic [2:0]       neg5_r;
  logic [LEN_W-1:0] len5_r;
  logic             deg5_r;
  logic [LEN_W-1:0] len_c;

  always_comb begin
    len_c = '0;
    for (int i = 0; i < SUM_W; i++) begin
      if (mx4_r[i]) len_c = LEN_W'(i + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      len5_r <= len_c;
      deg5_r <= (mx4_r == '0);
      mag5_r <= mag4_r;
      neg5_r <= neg4_r;
    end
  end

  // Stage 6: scale so that the largest magnitude has NORM_W bits.
  norm_vec_t        m6_r;
  logic [2:0]       neg6_r;
  logic             deg6_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (len5_r > LEN_W'(NORM_W))
          m6_r[i] <= NORM_W'(mag5_r[i] >> (len5_r - LEN_W'(NORM_W)));
        else
          m6_r[i] <= NORM_W'(mag5_r[i] << (LEN_W'(NORM_W) - len5_r));
      end
      neg6_r <= neg5_r;
      deg6_r <= deg5_r;
    end
  end

  // Stage 7: squares.
  logic [2*NORM_W-1:0] sq7_r [3];
  norm_vec_t           m7_r;
  logic [2:0]          neg7_r;
  logic                deg7_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) sq7_r[i] <= m6_r[i] * m6_r[i];
      m7_r   <= m6_r;
      neg7_r <= neg6_r;
      deg7_r <= deg6_r;
    end
  end

  // Stage 8: sum of squares.
  logic [Q_W-1:0] q8_r;
  norm_vec_t      m8_r;
  logic [2:0]     neg8_r;
  logic           deg8_r;

  always_ff @(posedge clk) begin
    if (en) begin
      q8_r   <= Q_W'(sq7_r[0]) + Q_W'(sq7_r[1]) + Q_W'(sq7_r[2]);
      m8_r   <= m7_r;
      neg8_r <= neg7_r;
      deg8_r <= deg7_r;
    end
  end

  // Square root, one result bit per stage.
  logic [ROOT_W-1:0] sn_r   [ROOT_STEPS];
  logic [ROOT_W-1:0] sr_r   [ROOT_STEPS];
  norm_vec_t         sm_r   [ROOT_STEPS];
  logic [2:0]        sneg_r [ROOT_STEPS];
  logic              sdeg_r [ROOT_STEPS];

  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
    localparam logic [ROOT_W-1:0] BITV = ROOT_W'(1) << (2 * (ROOT_STEPS - 1 - k));
    logic [ROOT_W-1:0] n_in, r_in, trial;
    norm_vec_t         m_in;
    logic [2:0]        neg_in;
    logic              deg_in;
    if (k == 0) begin : g_first
      assign n_in   = ROOT_W'(q8_r);
      assign r_in   = '0;
      assign m_in   = m8_r;
      assign neg_in = neg8_r;
      assign deg_in = deg8_r;
    end else begin : g_next
      assign n_in   = sn_r[k-1];
      assign r_in   = sr_r[k-1];
      assign m_in   = sm_r[k-1];
      assign neg_in = sneg_r[k-1];
      assign deg_in = sdeg_r[k-1];
    end
    assign trial = r_in + BITV;
    always_ff @(posedge clk) begin
      if (en) begin
        if (n_in >= trial) begin
          sn_r[k] <= n_in - trial;
          sr_r[k] <= (r_in >> 1) + BITV;
        end else begin
          sn_r[k] <= n_in;
          sr_r[k] <= r_in >> 1;
        end
        sm_r[k]   <= m_in;
        sneg_r[k] <= neg_in;
        sdeg_r[k] <= deg_in;
      end
    end
  end

  // Restoring division of each component by the root, one quotient bit per stage.
  logic [31:0]       dr_r   [DIV_STEPS];
  logic [REM_W-1:0]  drem_r [DIV_STEPS][3];
  logic [QUOT_W-1:0] dq_r   [DIV_STEPS][3];
  logic [2:0]        dneg_r [DIV_STEPS];
  logic              ddeg_r [DIV_STEPS];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    localparam int SH = DIV_STEPS - 1 - j;
    logic [31:0]       r_in;
    logic [REM_W-1:0]  rem_in [3];
    logic [QUOT_W-1:0] q_in   [3];
    logic [2:0]        neg_in;
    logic              deg_in;
    logic [REM_W-1:0]  dsh;
    if (j == 0) begin : g_first
      assign r_in   = sr_r[ROOT_STEPS-1][31:0];
      assign neg_in = sneg_r[ROOT_STEPS-1];
      assign deg_in = sdeg_r[ROOT_STEPS-1];
      for (genvar i = 0; i < 3; i++) begin : g_num
        assign rem_in[i] = (REM_W'(sm_r[ROOT_STEPS-1][i]) << FRAC_W)
                         + REM_W'(r_in >> 1);
        assign q_in[i]   = '0;
      end
    end else begin : g_next
      assign r_in   = dr_r[j-1];
      assign neg_in = dneg_r[j-1];
      assign deg_in = ddeg_r[j-1];
      for (genvar i = 0; i < 3; i++) begin : g_carry
        assign rem_in[i] = drem_r[j-1][i];
        assign q_in[i]   = dq_r[j-1][i];
      end
    end
    assign dsh = REM_W'(r_in) << SH;
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          if (rem_in[i] >= dsh) begin
            drem_r[j][i] <= rem_in[i] - dsh;
            dq_r[j][i]   <= q_in[i] | (QUOT_W'(1) << SH);
          end else begin
            drem_r[j][i] <= rem_in[i];
            dq_r[j][i]   <= q_in[i];
          end
        end
        dr_r[j]   <= r_in;
        dneg_r[j] <= neg_in;
        ddeg_r[j] <= deg_in;
      end
    end
  end

  // Output register.
  logic [DIR_W-1:0] dir_r [3];
  logic             deg_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        logic [DIR_W-1:0] c;
        c = DIR_W'(dq_r[DIV_STEPS-1][i]);
        if (ddeg_r[DIV_STEPS-1])
          dir_r[i] <= '0;
        else
          dir_r[i] <= dneg_r[DIV_STEPS-1][i] ? DIR_W'(-c) : c;
      end
      deg_r <= ddeg_r[DIV_STEPS-1];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, origin_r, dir_r[2], dir_r[1], dir_r[0]};
  assign out_tuser  = deg_r;

  a_zero_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[3*DIR_W-1:0] == '0)
    else $error("degenerate ray carries a nonzero direction");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |->
      ($signed(dir_r[0]) <= 16384 && $signed(dir_r[0]) >= -16384 &&
       $signed(dir_r[1]) <= 16384 && $signed(dir_r[1]) >= -16384 &&
       $signed(dir_r[2]) <= 16384 && $signed(dir_r[2]) >= -16384))
    else $error("direction component outside the unit range");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> v1_r)
    else $error("accepted transaction did not enter the pipeline");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(sv_r) && $stable(dv_r))
    else $error("pipeline moved while the output was stalled");

endmodule

>>> tb/sv/camera_ray_generator_unit_tb.sv
`timescale 1ns / 1ps
module camera_ray_generator_unit_tb;
  import cgr_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int PIPE_DEPTH  = 56;
  localparam int CYCLE_LIMIT = 400000;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct {
    logic [DIR_W-1:0] dir [3];
    logic [VEC_W-1:0] origin;
    logic             degenerate;
  } ray_t;

  class ray_scoreboard;
    logic [VEC_W-1:0] view_dir, col_step, row_step, origin;
    logic [RES_W-1:0] img_w, img_h;
    ray_t             pending_rays [$];
    int               errors;

    function void load_defaults();
      view_dir = VIEW_DIR_RST;
      col_step = COL_STEP_RST;
      row_step = ROW_STEP_RST;
      origin   = '0;
      img_w    = RES_W'(1);
      img_h    = RES_W'(1);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [VEC_W-1:0] val);
      case (idx)
        REG_VIEW_DIR:   view_dir = val;
        REG_COL_STEP:   col_step = val;
        REG_ROW_STEP:   row_step = val;
        REG_ORIGIN:     origin   = val;
        REG_IMG_WIDTH:  img_w    = val[RES_W-1:0];
        REG_IMG_HEIGHT: img_h    = val[RES_W-1:0];
        default: ;
      endcase
    endfunction

    function longint component(logic [VEC_W-1:0] v, int i);
      logic signed [LANE_W-1:0] c;
      c = v[LANE_W*i +: LANE_W];
      return longint'(c);
    endfunction

    function bit [63:0] floor_sqrt(bit [63:0] q);
      bit [63:0] r, t;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
        t = r | (64'd1 << b);
        if (t * t <= q) r = t;
      end
      return r;
    endfunction

    function void note_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
      longint    w, h, tx, ty, s;
      bit [63:0] mag [3];
      bit        neg [3];
      bit [63:0] mx, q, r, c;
      int        len;
      ray_t      ray;
      w = (img_w == 0) ? 1 : img_w;
      h = (img_h == 0) ? 1 : img_h;
      tx = longint'(px) - 8 * w;
      ty = longint'(py) - 8 * h;
      mx = 0;
      for (int i = 0; i < 3; i++) begin
        s = component(view_dir, i) * 16 + component(col_step, i) * tx
            + component(row_step, i) * ty;
        neg[i] = s < 0;
        mag[i] = neg[i] ? -s : s;
        if (mag[i] > mx) mx = mag[i];
      end
      ray.origin = origin;
      ray.degenerate = (mx == 0);
      for (int i = 0; i < 3; i++) ray.dir[i] = '0;
      if (mx != 0) begin
        len = 0;
        while (mx != 0) begin
          len++;
          mx = mx >> 1;
        end
        q = 0;
        for (int i = 0; i < 3; i++) begin
          if (len > NORM_W) mag[i] = mag[i] >> (len - NORM_W);
          else mag[i] = mag[i] << (NORM_W - len);
          q += mag[i] * mag[i];
        end
        r = floor_sqrt(q);
        for (int i = 0; i < 3; i++) begin
          c = ((mag[i] << FRAC_W) + (r >> 1)) / r;
          if (neg[i]) c = -c;
          ray.dir[i] = c[DIR_W-1:0];
        end
      end
      pending_rays.push_back(ray);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch on %s: got %h, expected %h", what, got, want);
      errors++;
    endtask

    task check_ray(logic [111:0] data, logic [0:0] user);
      ray_t want;
      if (pending_rays.size() == 0) begin
        report("unexpected ray", data[63:0], '0);
        return;
      end
      want = pending_rays.pop_front();
      if (data[15:0] !== want.dir[0])
        report("ray_dir_x", 64'(data[15:0]), 64'(want.dir[0]));
      if (data[31:16] !== want.dir[1])
        report("ray_dir_y", 64'(data[31:16]), 64'(want.dir[1]));
      if (data[47:32] !== want.dir[2])
        report("ray_dir_z", 64'(data[47:32]), 64'(want.dir[2]));
      if (data[107:48] !== want.origin)
        report("ray_origin", 64'(data[107:48]), 64'(want.origin));
      if (user[0] !== want.degenerate)
        report("degenerate", 64'(user[0]), 64'(want.degenerate));
    endtask
  endclass

  logic                 clk, rst_n;
  logic                 in_tvalid, in_tready;
  logic [31:0]          in_tdata;
  logic                 out_tvalid, out_tready;
  logic [111:0]         out_tdata;
  logic [0:0]           out_tuser;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_addr;
  logic [VEC_W-1:0]     cfg_wdata;

  ray_scoreboard sb;
  idle_mode_t    idle_mode;
  int            hold_phase;
  int            cycle_count = 0;

  camera_ray_generator_unit u_dut (.*);

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_pixel(in_tdata[15:0], in_tdata[31:16]);
    if (rst_n && out_tvalid && out_tready) sb.check_ray(out_tdata, out_tuser);
  end

  // A new hold request starts a long stretch with the receiver held off.
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_phase != hold_seen) begin
        hold_seen = hold_phase;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (idle_mode == IDLE_RECEIVER) begin
        out_tready <= ($urandom_range(99) >= 78);
      end else if (idle_mode == IDLE_BOTH) begin
        out_tready <= ($urandom_range(99) >= 6);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  function automatic logic [VEC_W-1:0] rand_vec();
    return VEC_W'({$urandom, $urandom});
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [VEC_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic end_writes();
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
    int gap;
    gap = (idle_mode == IDLE_SENDER) ? 78 : (idle_mode == IDLE_BOTH) ? 6 : 0;
    while ($urandom_range(99) < gap) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {py, px};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending_rays.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
  endtask

  task automatic random_camera();
    logic [VEC_W-1:0] small_step;
    write_reg(REG_VIEW_DIR, ($urandom_range(7) == 0) ? '0 : rand_vec());
    small_step = {40'd0, 4'd0, 16'($urandom)};
    write_reg(REG_COL_STEP, $urandom_range(1) ? rand_vec() : small_step);
    write_reg(REG_ROW_STEP, $urandom_range(1) ? rand_vec() : {small_step[19:0], 40'd0});
    write_reg(REG_ORIGIN, rand_vec());
    case ($urandom_range(3))
      0: write_reg(REG_IMG_WIDTH, 60'($urandom_range(8191)));
      1: write_reg(REG_IMG_WIDTH, 60'd4096);
      default: write_reg(REG_IMG_WIDTH, 60'($urandom_range(1, 1024)));
    endcase
    case ($urandom_range(3))
      0: write_reg(REG_IMG_HEIGHT, 60'($urandom_range(8191)));
      1: write_reg(REG_IMG_HEIGHT, 60'd1);
      default: write_reg(REG_IMG_HEIGHT, 60'($urandom_range(1, 1024)));
    endcase
    end_writes();
  endtask

  initial begin
    logic [PIX_W-1:0] cx, cy;
    sb = new();
    sb.load_defaults();
    sb.errors = 0;
    idle_mode = IDLE_NONE;
    hold_phase = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default camera, then corners and the image center.
    send_pixel(16'd0, 16'd0);
    send_pixel(16'hFFFF, 16'hFFFF);
    send_pixel(16'd8, 16'd8);
    send_pixel(16'hFFFF, 16'd0);
    drain();

    // A zero view direction at the image center gives a degenerate ray.
    write_reg(REG_VIEW_DIR, '0);
    write_reg(REG_ORIGIN, 60'hFFF_FFFF_FFFF_FFFF);
    write_reg(REG_IMG_WIDTH, 60'd0);
    write_reg(REG_IMG_HEIGHT, 60'd8191);
    write_reg(REG_SPARE_LO, rand_vec());
    write_reg(REG_SPARE_HI, rand_vec());
    end_writes();
    send_pixel(16'd8, 16'd65528);
    send_pixel(16'd0, 16'd0);
    send_pixel(16'hFFFF, 16'hFFFF);
    drain();

    // Extreme lane values in every basis vector.
    write_reg(REG_VIEW_DIR, {3{20'h80000}});
    write_reg(REG_COL_STEP, {3{20'h7FFFF}});
    write_reg(REG_ROW_STEP, {20'h80000, 20'h7FFFF, 20'h80000});
    write_reg(REG_IMG_WIDTH, 60'd8191);
    write_reg(REG_IMG_HEIGHT, 60'd0);
    end_writes();
    send_pixel(16'd0, 16'd0);
    send_pixel(16'hFFFF, 16'hFFFF);
    send_pixel(16'd65528, 16'd8);
    send_pixel(16'h5555, 16'hAAAA);
    send_pixel(16'hAAAA, 16'h5555);
    drain();

    write_reg(REG_VIEW_DIR, {3{20'h7FFFF}});
    write_reg(REG_COL_STEP, '0);
    write_reg(REG_ROW_STEP, '0);
    write_reg(REG_ORIGIN, '0);
    end_writes();
    send_pixel(16'd1, 16'd1);
    send_pixel(16'd12345, 16'd54321);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      random_camera();
      idle_mode = idle_mode_t'(phase % 4);
      if (idle_mode == IDLE_NONE) hold_phase = phase + 1;
      cx = 16'(8 * ((sb.img_w == 0) ? 1 : sb.img_w));
      cy = 16'(8 * ((sb.img_h == 0) ? 1 : sb.img_h));
      for (int n = 0; n < 105; n++) begin
        case ($urandom_range(9))
          0: send_pixel(cx, cy);
          1, 2: send_pixel(16'($urandom), 16'($urandom));
          default: send_pixel(16'($urandom_range(cx * 2)), 16'($urandom_range(cy * 2)));
        endcase
      end
      drain();
    end
    idle_mode = IDLE_NONE;

    if (sb.errors == 0 && sb.pending_rays.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
